// File: rtl/rainbow_text_colorizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Rainbow text colorizer assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RAINBOW_TEXT_COLORIZER_UNIT_MACROS_SVH
`define RAINBOW_TEXT_COLORIZER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication or plain condition, sampled on clk, off in reset.
`define RTC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtc check failed");
// Condition in one cycle implies result in the next.
`define RTC_CHECK_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("rtc next-cycle check failed");
`else
`define RTC_CHECK(lbl, prop)
`define RTC_CHECK_NEXT(lbl, cond, res)
`endif

`endif

// File: rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and constants of the rainbow text colorizer.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Rainbow phases: which channel ramps and in which direction
  typedef enum logic [2:0] {
    PH_G_UP = 3'd0,
    PH_R_DN = 3'd1,
    PH_B_UP = 3'd2,
    PH_G_DN = 3'd3,
    PH_R_UP = 3'd4,
    PH_B_DN = 3'd5
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TAB  = 1'b1
  } state_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [7:0] color_low;
    logic [7:0] color_high;
    logic [7:0] char_step;
    logic [7:0] line_step;
  } cfg_t;

  // Register indexes
  localparam logic [1:0] REG_COLOR_LOW  = 2'd0;
  localparam logic [1:0] REG_COLOR_HIGH = 2'd1;
  localparam logic [1:0] REG_CHAR_STEP  = 2'd2;
  localparam logic [1:0] REG_LINE_STEP  = 2'd3;

  localparam logic [7:0] COLOR_LOW_RST  = 8'd80;
  localparam logic [7:0] COLOR_HIGH_RST = 8'd255;
  localparam logic [7:0] CHAR_STEP_RST  = 8'd10;
  localparam logic [7:0] LINE_STEP_RST  = 8'd30;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_TAB     = 8'h09;

  localparam color_t COLOR_RST = '{phase: PH_G_UP, red: COLOR_HIGH_RST,
                                   green: COLOR_LOW_RST, blue: COLOR_LOW_RST};

endpackage

// File: rtl/rtc_step_unit.sv
// ----------------------------------------------------------------------------
// rtc_step_unit
// Shared rainbow step: ramps one channel by d and clamps to the bounds.
// ----------------------------------------------------------------------------
module rtc_step_unit (
  input  rtc_pkg::color_t src,
  input  logic [7:0]      step_d,
  input  logic [7:0]      color_low,
  input  logic [7:0]      color_high,
  output rtc_pkg::color_t res
);

  logic       valid_ph;
  logic       going_up;
  logic [7:0] ch;
  logic [8:0] sum;
  logic [8:0] lim;
  logic [7:0] diff;
  logic       hit;
  logic [7:0] ch_new;
  rtc_pkg::phase_t ph_next;

  always_comb begin
    valid_ph = 1'b1;
    going_up = 1'b1;
    ch       = src.green;
    ph_next  = rtc_pkg::PH_G_UP;
    unique case (src.phase)
      rtc_pkg::PH_G_UP: begin ch = src.green; going_up = 1'b1; ph_next = rtc_pkg::PH_R_DN; end
      rtc_pkg::PH_R_DN: begin ch = src.red;   going_up = 1'b0; ph_next = rtc_pkg::PH_B_UP; end
      rtc_pkg::PH_B_UP: begin ch = src.blue;  going_up = 1'b1; ph_next = rtc_pkg::PH_G_DN; end
      rtc_pkg::PH_G_DN: begin ch = src.green; going_up = 1'b0; ph_next = rtc_pkg::PH_R_UP; end
      rtc_pkg::PH_R_UP: begin ch = src.red;   going_up = 1'b1; ph_next = rtc_pkg::PH_B_DN; end
      rtc_pkg::PH_B_DN: begin ch = src.blue;  going_up = 1'b0; ph_next = rtc_pkg::PH_G_UP; end
      default: valid_ph = 1'b0;
    endcase
  end

  // up: ch + d >= high clamps; down: ch - d <= low, i.e. ch <= low + d
  assign sum  = {1'b0, ch} + {1'b0, step_d};
  assign lim  = {1'b0, color_low} + {1'b0, step_d};
  assign diff = ch - step_d;
  assign hit  = going_up ? (sum >= {1'b0, color_high}) : ({1'b0, ch} <= lim);

  always_comb begin
    if (hit) begin
      ch_new = going_up ? color_high : color_low;
    end else begin
      ch_new = going_up ? sum[7:0] : diff;
    end
    res = src;
    if (valid_ph) begin
      if (hit) res.phase = ph_next;
      unique case (src.phase)
        rtc_pkg::PH_R_DN, rtc_pkg::PH_R_UP: res.red   = ch_new;
        rtc_pkg::PH_B_UP, rtc_pkg::PH_B_DN: res.blue  = ch_new;
        default:                            res.green = ch_new;
      endcase
    end
  end

endmodule

// File: rtl/rtc_ctrl.sv
// ----------------------------------------------------------------------------
// rtc_ctrl
// Byte classifier, color state and tab sequencer around the step unit.
// ----------------------------------------------------------------------------
`include "rainbow_text_colorizer_unit_macros.svh"

module rtc_ctrl #(
  parameter int TAB_WIDTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic            out_tuser,
  input  rtc_pkg::cfg_t   cfg,
  output rtc_pkg::color_t step_src,
  output logic [7:0]      step_d,
  input  rtc_pkg::color_t step_res
);

  localparam int COL_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TAB_WIDTH - 1);

  rtc_pkg::state_t state_r, state_nxt;
  rtc_pkg::color_t cur_r, cur_nxt;
  rtc_pkg::color_t line_r, line_nxt;
  logic [COL_W-1:0] col_r, col_nxt, col_inc;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_tuser_r, out_tuser_nxt;
  logic [31:0]      out_tdata_r, out_tdata_nxt;

  logic acc;
  logic is_nl, is_tab, is_cont;

  assign in_tready = (state_r == rtc_pkg::ST_IDLE) && (!out_tvalid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign is_nl     = (in_tdata == rtc_pkg::BYTE_NEWLINE);
  assign is_tab    = (in_tdata == rtc_pkg::BYTE_TAB);
  assign is_cont   = (in_tdata[7:6] == 2'b10);
  assign col_inc   = (col_r == COL_LAST) ? '0 : col_r + COL_W'(1);

  // Newline steps the line-start color, everything else the current color
  always_comb begin
    if (state_r == rtc_pkg::ST_IDLE && is_nl) begin
      step_src = line_r;
      step_d   = cfg.line_step;
    end else begin
      step_src = cur_r;
      step_d   = cfg.char_step;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    unique case (state_r)
      rtc_pkg::ST_IDLE: begin
        if (acc) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = 1'b0;
          out_tdata_nxt  = {24'd0, in_tdata};
          if (is_nl) begin
            line_nxt = step_res;
            cur_nxt  = step_res;
            col_nxt  = '0;
          end else if (!is_cont) begin
            cur_nxt       = step_res;
            col_nxt       = col_inc;
            out_tuser_nxt = 1'b1;
            out_tdata_nxt = {step_res.blue, step_res.green, step_res.red, in_tdata};
            if (is_tab && col_inc != '0) state_nxt = rtc_pkg::ST_TAB;
          end
        end
      end
      rtc_pkg::ST_TAB: begin
        // one extra step per column until the next tab stop
        cur_nxt = step_res;
        col_nxt = col_inc;
        if (col_inc == '0) state_nxt = rtc_pkg::ST_IDLE;
      end
      default: state_nxt = rtc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rtc_pkg::ST_IDLE;
      cur_r        <= rtc_pkg::COLOR_RST;
      line_r       <= rtc_pkg::COLOR_RST;
      col_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tuser_r <= out_tuser_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  `RTC_CHECK(a_tab_blocks_input, (state_r == rtc_pkg::ST_TAB) |-> !in_tready)
  `RTC_CHECK(a_tab_col_nonzero, (state_r == rtc_pkg::ST_TAB) |-> (col_r != '0))
  `RTC_CHECK(a_col_in_range, col_r <= COL_LAST)
  `RTC_CHECK(a_uncolored_zero, (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r[31:8] == 24'd0))
  `RTC_CHECK_NEXT(a_newline_col, (acc && is_nl), (col_r == '0 && out_tvalid_r && !out_tuser_r))

endmodule

// File: rtl/rainbow_text_colorizer_unit.sv
// ----------------------------------------------------------------------------
// rainbow_text_colorizer_unit
// Rainbow text colorizer: one byte in, the byte plus an optional color out.
// Result registered in the cycle after the input transaction.
// Throughput: one byte per cycle while the output is not stalled, except a tab,
//   which holds off input for one extra step per column up to the next tab stop
//   (up to TAB_WIDTH-1). The extra steps are iterations of the single shared step unit.
// Reset (rst_n, synchronous, active low): config back to 80/255/10/30,
//   line and current colors to high/low/low in phase 0, column 0.
// ----------------------------------------------------------------------------
module rainbow_text_colorizer_unit #(
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] out_byte, [15:8] red, [23:16] green, [31:24] blue
  output logic        out_tuser,   // [0] has_color
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  rtc_pkg::cfg_t   cfg_r;
  rtc_pkg::color_t step_src;
  rtc_pkg::color_t step_res;
  logic [7:0]      step_d;

  // Config registers; expected to be written only with no transaction in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_low  <= rtc_pkg::COLOR_LOW_RST;
      cfg_r.color_high <= rtc_pkg::COLOR_HIGH_RST;
      cfg_r.char_step  <= rtc_pkg::CHAR_STEP_RST;
      cfg_r.line_step  <= rtc_pkg::LINE_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rtc_pkg::REG_COLOR_LOW:  cfg_r.color_low  <= cfg_wdata;
        rtc_pkg::REG_COLOR_HIGH: cfg_r.color_high <= cfg_wdata;
        rtc_pkg::REG_CHAR_STEP:  cfg_r.char_step  <= cfg_wdata;
        rtc_pkg::REG_LINE_STEP:  cfg_r.line_step  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The one ramp/clamp unit, shared by newline, character and tab steps
  rtc_step_unit u_step (
    .src        (step_src),
    .step_d     (step_d),
    .color_low  (cfg_r.color_low),
    .color_high (cfg_r.color_high),
    .res        (step_res)
  );

  // Sequencer: classifies the byte, owns color state and the output register
  rtc_ctrl #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg        (cfg_r),
    .step_src   (step_src),
    .step_d     (step_d),
    .step_res   (step_res)
  );

endmodule
